### src/rmv_pkg.sv
package rmv_pkg;

    localparam int MAX_DIM   = 1024;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 3;
    localparam int PIX_W     = 8;
    localparam int POS_W     = 10;
    localparam int CNT_W     = 21;
    localparam int SUM_W     = 28;
    localparam int SQ_W      = 36;
    localparam int MEAN_W    = 16;
    localparam int VAR_W     = 22;
    localparam int FRAC_W    = 8;
    localparam int ADD_W     = 64;
    localparam int DEN_W     = 2 * CNT_W;
    localparam int ITER_W    = $clog2(ADD_W);

    localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(1 << 20);
    localparam logic [CFG_W-1:0] DIM_MAX     = CFG_W'(MAX_DIM);

    localparam logic [CFG_IDX_W-1:0] CFG_COL_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_END   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_END   = 3'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_CS,
        ST_MUL_SS,
        ST_SUB,
        ST_DIV_M,
        ST_MUL_CC,
        ST_DIV_V,
        ST_HOLD
    } t_state;

endpackage

### src/region_mean_variance.sv
// Region mean and variance over a raster pixel stream.
// Input channel: pixel, col, row, frame_last under i_in_valid / o_in_ready.
// Pixels inside the half-open rectangle set by the four config registers
// (corners clamped to MAX_DIM and ordered) add to count, sum and sum of
// squares; ordinary pixels are taken one per cycle while the block is idle.
// A request with frame_last closes the frame: the pixel is counted, the
// accumulators are cleared, and the block drops ready while one shared
// 64-bit add/subtract unit runs shift-add multiplies (21, 28, 21 steps),
// one subtract and two restoring divides (36 and 64 steps).
// The result (mean_q8, variance_q8, pixel_count, empty_res) is loaded from
// the hold state; an empty region goes from frame_last straight to hold.
// The result sits in an output register; ready returns once it is loaded,
// so the next frame streams in while the receiver stalls. A later frame's
// result waits in the hold state until the output register is free.
// Config writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at once; the user
// makes them only while idle, unchecked. Reset clears config, accumulators and valid.
module region_mean_variance (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rmv_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rmv_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [rmv_pkg::PIX_W-1:0]       i_in_pixel,
    input  logic [rmv_pkg::POS_W-1:0]       i_in_col,
    input  logic [rmv_pkg::POS_W-1:0]       i_in_row,
    input  logic                            i_in_frame_last,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [rmv_pkg::MEAN_W-1:0]      o_out_mean_q8,
    output logic [rmv_pkg::VAR_W-1:0]       o_out_variance_q8,
    output logic [rmv_pkg::CNT_W-1:0]       o_out_pixel_count,
    output logic                            o_out_empty_res
);
    import rmv_pkg::*;

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_col_start, r_col_end, r_row_start, r_row_end;

    logic [SUM_W-1:0] r_acc_sum, n_acc_sum;
    logic [SQ_W-1:0]  r_acc_sq,  n_acc_sq;
    logic [CNT_W-1:0] r_acc_cnt, n_acc_cnt;

    logic [SUM_W-1:0] r_sum, n_sum;
    logic [SQ_W-1:0]  r_sq,  n_sq;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_empty_q, n_empty_q;

    logic [ADD_W-1:0]  r_md, n_md;
    logic [SUM_W-1:0]  r_mr, n_mr;
    logic [ADD_W-1:0]  r_acc, n_acc;
    logic [ADD_W-1:0]  r_tmp, n_tmp;
    logic [ADD_W-1:0]  r_dvd, n_dvd;
    logic [DEN_W-1:0]  r_div, n_div;
    logic [DEN_W-1:0]  r_rem, n_rem;
    logic [VAR_W-1:0]  r_quo, n_quo;
    logic [MEAN_W-1:0] r_mean_q, n_mean_q;
    logic [ITER_W-1:0] r_iter, n_iter;

    logic              r_out_valid, n_out_valid;
    logic [MEAN_W-1:0] r_out_mean, n_out_mean;
    logic [VAR_W-1:0]  r_out_var, n_out_var;
    logic [CNT_W-1:0]  r_out_cnt, n_out_cnt;
    logic              r_out_empty, n_out_empty;

    // region bounds
    logic [CFG_W-1:0] cs, ce, rs, re, c_lo, c_hi, r_lo, r_hi;
    logic             in_region, in_take, inc;
    logic [CNT_W-1:0] a_cnt;
    logic [SUM_W-1:0] a_sum;
    logic [SQ_W-1:0]  a_sq;
    logic [2*PIX_W-1:0] pix_sq;

    // shared add/subtract unit
    logic [ADD_W-1:0] add_a, add_b, add_s;
    logic             add_sub, add_c;
    logic [DEN_W:0]   div_t;
    logic [ADD_W-1:0] mul_res;

    always_comb begin
        cs = (r_col_start > DIM_MAX) ? DIM_MAX : r_col_start;
        ce = (r_col_end   > DIM_MAX) ? DIM_MAX : r_col_end;
        rs = (r_row_start > DIM_MAX) ? DIM_MAX : r_row_start;
        re = (r_row_end   > DIM_MAX) ? DIM_MAX : r_row_end;
        c_lo = (cs < ce) ? cs : ce;
        c_hi = (cs < ce) ? ce : cs;
        r_lo = (rs < re) ? rs : re;
        r_hi = (rs < re) ? re : rs;
        in_region = (CFG_W'(i_in_col) >= c_lo) && (CFG_W'(i_in_col) < c_hi)
                 && (CFG_W'(i_in_row) >= r_lo) && (CFG_W'(i_in_row) < r_hi);
        in_take = i_in_valid && (r_state == ST_IDLE);
        inc     = in_take && in_region && (r_acc_cnt < COUNT_LIMIT);
        pix_sq  = i_in_pixel * i_in_pixel;
        a_cnt = inc ? r_acc_cnt + CNT_W'(1) : r_acc_cnt;
        a_sum = inc ? r_acc_sum + SUM_W'(i_in_pixel) : r_acc_sum;
        a_sq  = inc ? r_acc_sq + SQ_W'(pix_sq) : r_acc_sq;
    end

    always_comb begin
        div_t   = {r_rem, r_dvd[ADD_W-1]};
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        unique case (r_state)
            ST_MUL_CS, ST_MUL_SS, ST_MUL_CC: begin
                add_a = r_acc;
                add_b = r_md;
            end
            ST_SUB: begin
                add_a   = r_tmp;
                add_b   = r_acc;
                add_sub = 1'b1;
            end
            ST_DIV_M, ST_DIV_V: begin
                add_a   = ADD_W'(div_t);
                add_b   = ADD_W'(r_div);
                add_sub = 1'b1;
            end
            default: begin
                add_a = '0;
            end
        endcase
        {add_c, add_s} = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                       + (ADD_W+1)'(add_sub);
        mul_res = r_mr[0] ? add_s : r_acc;
    end

    always_comb begin
        n_state     = r_state;
        n_acc_sum   = r_acc_sum;
        n_acc_sq    = r_acc_sq;
        n_acc_cnt   = r_acc_cnt;
        n_sum       = r_sum;
        n_sq        = r_sq;
        n_cnt       = r_cnt;
        n_empty_q   = r_empty_q;
        n_md        = r_md;
        n_mr        = r_mr;
        n_acc       = r_acc;
        n_tmp       = r_tmp;
        n_dvd       = r_dvd;
        n_div       = r_div;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_mean_q    = r_mean_q;
        n_iter      = r_iter;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_mean  = r_out_mean;
        n_out_var   = r_out_var;
        n_out_cnt   = r_out_cnt;
        n_out_empty = r_out_empty;

        unique case (r_state)
            ST_IDLE: begin
                if (in_take && i_in_frame_last) begin
                    n_acc_sum = '0;
                    n_acc_sq  = '0;
                    n_acc_cnt = '0;
                    n_sum     = a_sum;
                    n_sq      = a_sq;
                    n_cnt     = a_cnt;
                    n_empty_q = (a_cnt == '0);
                    n_md      = ADD_W'(a_sq);
                    n_mr      = SUM_W'(a_cnt);
                    n_acc     = '0;
                    n_iter    = ITER_W'(CNT_W - 1);
                    n_state   = (a_cnt == '0) ? ST_HOLD : ST_MUL_CS;
                end else if (in_take) begin
                    n_acc_sum = a_sum;
                    n_acc_sq  = a_sq;
                    n_acc_cnt = a_cnt;
                end
            end
            ST_MUL_CS, ST_MUL_SS, ST_MUL_CC: begin
                n_acc  = mul_res;
                n_md   = r_md << 1;
                n_mr   = r_mr >> 1;
                n_iter = r_iter - ITER_W'(1);
                if (r_iter == '0) begin
                    if (r_state == ST_MUL_CS) begin
                        n_tmp   = mul_res;
                        n_md    = ADD_W'(r_sum);
                        n_mr    = r_sum;
                        n_acc   = '0;
                        n_iter  = ITER_W'(SUM_W - 1);
                        n_state = ST_MUL_SS;
                    end else if (r_state == ST_MUL_SS) begin
                        n_state = ST_SUB;
                    end else begin
                        n_div   = mul_res[DEN_W-1:0];
                        n_dvd   = r_tmp;
                        n_rem   = '0;
                        n_quo   = '0;
                        n_iter  = ITER_W'(ADD_W - 1);
                        n_state = ST_DIV_V;
                    end
                end
            end
            ST_SUB: begin
                // dividend of the variance: (count*sq - sum^2) << 8
                n_tmp   = add_s << FRAC_W;
                n_dvd   = ADD_W'({r_sum, FRAC_W'(0)}) << (ADD_W - SUM_W - FRAC_W);
                n_div   = DEN_W'(r_cnt);
                n_rem   = '0;
                n_quo   = '0;
                n_iter  = ITER_W'(SUM_W + FRAC_W - 1);
                n_state = ST_DIV_M;
            end
            ST_DIV_M, ST_DIV_V: begin
                n_dvd  = r_dvd << 1;
                n_rem  = add_c ? add_s[DEN_W-1:0] : div_t[DEN_W-1:0];
                n_quo  = {r_quo[VAR_W-2:0], add_c};
                n_iter = r_iter - ITER_W'(1);
                if (r_iter == '0) begin
                    if (r_state == ST_DIV_M) begin
                        n_mean_q = n_quo[MEAN_W-1:0];
                        n_md     = ADD_W'(r_cnt);
                        n_mr     = SUM_W'(r_cnt);
                        n_acc    = '0;
                        n_iter   = ITER_W'(CNT_W - 1);
                        n_state  = ST_MUL_CC;
                    end else begin
                        n_state = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_mean  = r_empty_q ? '0 : r_mean_q;
                    n_out_var   = r_empty_q ? '0 : r_quo;
                    n_out_cnt   = r_cnt;
                    n_out_empty = r_empty_q;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_acc_sum   <= '0;
            r_acc_sq    <= '0;
            r_acc_cnt   <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_acc_sum   <= n_acc_sum;
            r_acc_sq    <= n_acc_sq;
            r_acc_cnt   <= n_acc_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_start <= '0;
            r_col_end   <= '0;
            r_row_start <= '0;
            r_row_end   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COL_START: r_col_start <= i_cfg_data;
                CFG_COL_END:   r_col_end   <= i_cfg_data;
                CFG_ROW_START: r_row_start <= i_cfg_data;
                CFG_ROW_END:   r_row_end   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum       <= n_sum;
        r_sq        <= n_sq;
        r_cnt       <= n_cnt;
        r_empty_q   <= n_empty_q;
        r_md        <= n_md;
        r_mr        <= n_mr;
        r_acc       <= n_acc;
        r_tmp       <= n_tmp;
        r_dvd       <= n_dvd;
        r_div       <= n_div;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_mean_q    <= n_mean_q;
        r_iter      <= n_iter;
        r_out_mean  <= n_out_mean;
        r_out_var   <= n_out_var;
        r_out_cnt   <= n_out_cnt;
        r_out_empty <= n_out_empty;
    end

    assign o_in_ready        = (r_state == ST_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_out_mean_q8     = r_out_mean;
    assign o_out_variance_q8 = r_out_var;
    assign o_out_pixel_count = r_out_cnt;
    assign o_out_empty_res   = r_out_empty;

`ifndef NO_ASSERTIONS
    a_last_drops_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_frame_last) |=> !o_in_ready)
        else $error("ready stayed high after frame_last request");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc_cnt <= COUNT_LIMIT)
        else $error("pixel count above limit");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV_M || r_state == ST_DIV_V) |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");

    a_hold_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HOLD) |-> (r_empty_q == (r_cnt == '0)))
        else $error("empty flag disagrees with count");
`endif

endmodule
